// File: hdl/gbps_pkg.sv
// Shared types and codes for the grid BFS path solver.
`default_nettype none
package gbps_pkg;
  localparam int unsigned OP_W = 2;
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [2:0] K_OPEN    = 3'd0;
  localparam logic [2:0] K_WALL    = 3'd1;
  localparam logic [2:0] K_START   = 3'd2;
  localparam logic [2:0] K_GOAL    = 3'd3;
  localparam logic [2:0] K_PATH    = 3'd4;
  localparam logic [2:0] K_VISITED = 3'd5;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_NOPATH  = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic [1:0] cell_kind;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  cell_state;
    logic [1:0]  solve_status;
    logic [11:0] path_steps;
  } out_item_t;
endpackage
`default_nettype wire

// File: hdl/gbps_if.sv
// Valid/ready channel interfaces for item and result beats.
`default_nettype none
interface gbps_in_if import gbps_pkg::*; (input wire logic clk);
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gbps_out_if import gbps_pkg::*; (input wire logic clk);
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/gbps_nbr.sv
// Shared neighbor unit: steps a cell position by one direction and bounds-checks it.
`default_nettype none
module gbps_nbr import gbps_pkg::*; #(
  parameter int unsigned ROWS = 64,
  parameter int unsigned COLS = 64,
  parameter int unsigned RW = 6,
  parameter int unsigned CW = 6
) (
  input  wire logic [RW-1:0] row,
  input  wire logic [CW-1:0] col,
  input  wire logic [1:0]    dir,
  input  wire logic          back,
  output logic [RW-1:0]      nrow,
  output logic [CW-1:0]      ncol,
  output logic               ok
);
  logic [1:0] d;
  always_comb begin
    // Going back along a parent link is the opposite direction.
    d = back ? {dir[1], ~dir[0]} : dir;
    nrow = row;
    ncol = col;
    ok = 1'b1;
    case (d)
      DIR_UP: begin
        ok = (row != '0);
        nrow = row - RW'(1);
      end
      DIR_DOWN: begin
        ok = ({1'b0, row} < (RW+1)'(ROWS - 1));
        nrow = row + RW'(1);
      end
      DIR_LEFT: begin
        ok = (col != '0);
        ncol = col - CW'(1);
      end
      default: begin
        ok = ({1'b0, col} < (CW+1)'(COLS - 1));
        ncol = col + CW'(1);
      end
    endcase
  end
endmodule
`default_nettype wire

// File: hdl/grid_bfs_path_solver_unit.sv
// Top level of the grid BFS path solver.
//  channel  dir  handshake     payload
//  in_*     in   valid/ready   opcode, cell_row, cell_col, cell_kind
//  out_*    out  valid/ready   cell_state, solve_status, path_steps
// After reset a clearing pass of one cycle per memory word (each axis rounded up
// to a power of two) runs first. A solve scans every grid cell, then pops queued
// cells and tests their neighbors, then traces the parent links back from the
// goal, marking each cell on the way as path. The cell memory is single-port.
// in_ready is low while a beat is being worked and while a result waits.
`default_nettype none
module grid_bfs_path_solver_unit import gbps_pkg::*; #(
  parameter int unsigned ROWS = 64,
  parameter int unsigned COLS = 64
) (
  input wire logic   clk,
  input wire logic   rst_n,
  gbps_in_if.sink    in_ch,
  gbps_out_if.source out_ch
);
  localparam int unsigned RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned AW = RW + CW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned QW = $clog2(ROWS * COLS + 1);

  typedef enum logic [11:0] {
    S_CLR   = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_ACC   = 12'b000000000100,
    S_SCANR = 12'b000000001000,
    S_SCANW = 12'b000000010000,
    S_QPOP  = 12'b000000100000,
    S_QDAT  = 12'b000001000000,
    S_NRD   = 12'b000010000000,
    S_NCHK  = 12'b000100000000,
    S_TRD   = 12'b001000000000,
    S_TCHK  = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  // Memories: cell kind + visited bit + parent direction, and the queue.
  logic [5:0]    cmem [DEPTH];
  logic [AW-1:0] qmem [DEPTH];
  logic [5:0]    crd_r;
  logic [AW-1:0] qrd_r;

  state_t        st_r, st_nxt;
  in_item_t      item_r;
  out_item_t     res_r, res_nxt;
  logic          ovld_r, ovld_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] nb_r, nb_nxt;
  logic [1:0]    dir_r, dir_nxt;
  logic [AW-1:0] spos_r, spos_nxt, gpos_r, gpos_nxt;
  logic          sseen_r, sseen_nxt, gseen_r, gseen_nxt;
  logic [QW-1:0] qh_r, qh_nxt, qt_r, qt_nxt;
  logic [11:0]   steps_r, steps_nxt;
  logic [QW-1:0] guard_r, guard_nxt;
  logic          visit_r, visit_nxt;

  logic          cwe, qwe;
  logic [AW-1:0] caddr, qwaddr, qraddr;
  logic [5:0]    cwdata;
  logic [AW-1:0] qwdata;

  logic [RW-1:0] nrow;
  logic [CW-1:0] ncol;
  logic          nok, nback;
  logic [1:0]    ndir;
  logic [AW-1:0] nbase;
  logic          in_grid;

  gbps_nbr #(.ROWS(ROWS), .COLS(COLS), .RW(RW), .CW(CW)) u_nbr (
    .row(nbase[AW-1:CW]), .col(nbase[CW-1:0]), .dir(ndir), .back(nback),
    .nrow(nrow), .ncol(ncol), .ok(nok)
  );

  always_ff @(posedge clk) begin
    if (cwe) cmem[caddr] <= cwdata;
    crd_r <= cmem[caddr];
    if (qwe) qmem[qwaddr] <= qwdata;
    qrd_r <= qmem[qraddr];
  end

  assign in_grid = ({3'b0, item_r.cell_row} < 9'(ROWS)) &&
                   ({3'b0, item_r.cell_col} < 9'(COLS));
  assign in_ch.ready = (st_r == S_IDLE) && !ovld_r;
  assign out_ch.valid = ovld_r;
  assign out_ch.data  = res_r;

  always_comb begin
    st_nxt = st_r; res_nxt = res_r; ovld_nxt = ovld_r; cnt_nxt = cnt_r;
    cur_nxt = cur_r; nb_nxt = nb_r; dir_nxt = dir_r; spos_nxt = spos_r;
    gpos_nxt = gpos_r; sseen_nxt = sseen_r; gseen_nxt = gseen_r;
    qh_nxt = qh_r; qt_nxt = qt_r; steps_nxt = steps_r; guard_nxt = guard_r;
    visit_nxt = visit_r;
    cwe = 1'b0; qwe = 1'b0; caddr = cnt_r[AW-1:0]; cwdata = '0;
    qwaddr = qt_r[AW-1:0]; qwdata = nb_r; qraddr = qh_r[AW-1:0];
    ndir = dir_r; nback = 1'b0; nbase = cur_r;
    if (ovld_r && out_ch.ready) ovld_nxt = 1'b0;
    case (st_r)
      S_CLR: begin
        cwe = 1'b1; cwdata = '0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[AW-1:0] == AW'(DEPTH - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) st_nxt = S_ACC;
        caddr = {RW'(in_ch.data.cell_row), CW'(in_ch.data.cell_col)};
        cnt_nxt = '0;
      end
      S_ACC: begin
        res_nxt = '0;
        caddr = {RW'(item_r.cell_row), CW'(item_r.cell_col)};
        case (item_r.opcode)
          OP_WRITE: begin
            cwe = in_grid; cwdata = {3'b0, 1'b0, item_r.cell_kind};
            ovld_nxt = 1'b1; st_nxt = S_IDLE;
          end
          OP_READ: begin
            if (in_grid) res_nxt.cell_state = crd_r[2:0];
            ovld_nxt = 1'b1; st_nxt = S_IDLE;
          end
          OP_SOLVE: begin
            sseen_nxt = 1'b0; gseen_nxt = 1'b0; spos_nxt = '0; gpos_nxt = '0;
            cnt_nxt = '0; st_nxt = S_SCANR;
          end
          default: begin
            ovld_nxt = 1'b1; st_nxt = S_IDLE;
          end
        endcase
      end
      S_SCANR: begin
        // Out-of-grid addresses of a padded memory are skipped.
        nbase = cnt_r[AW-1:0];
        if ({1'b0, cnt_r[AW-1:CW]} >= (RW+1)'(ROWS) ||
            {1'b0, cnt_r[CW-1:0]} >= (CW+1)'(COLS)) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r[AW-1:0] == AW'(DEPTH - 1)) st_nxt = S_SCANW;
        end else begin
          st_nxt = S_SCANW;
        end
        if (cnt_r[AW]) st_nxt = S_SCANW;
      end
      S_SCANW: begin
        if (cnt_r[AW] || cnt_r[AW-1:0] == '1 &&
            ({1'b0, cnt_r[AW-1:CW]} >= (RW+1)'(ROWS) ||
             {1'b0, cnt_r[CW-1:0]} >= (CW+1)'(COLS))) begin
          cnt_nxt = {1'b1, cnt_r[AW-1:0]};
        end else begin
          // Clear visited mark and stale path/visited kinds.
          cwe = 1'b1;
          cwdata = {3'b0, 1'b0, crd_r[1:0]};
          if (crd_r[2:0] == K_PATH || crd_r[2:0] == K_VISITED) cwdata = '0;
          else cwdata = {crd_r[5:4], 1'b0, crd_r[2:0]};
          if (crd_r[2:0] == K_START) begin spos_nxt = cnt_r[AW-1:0]; sseen_nxt = 1'b1; end
          if (crd_r[2:0] == K_GOAL) begin gpos_nxt = cnt_r[AW-1:0]; gseen_nxt = 1'b1; end
          cnt_nxt = cnt_r + 1'b1;
        end
        if (cnt_nxt[AW] || cnt_r[AW]) begin
          if (!(sseen_nxt && gseen_nxt)) begin
            res_nxt.solve_status = ST_MISSING; ovld_nxt = 1'b1; st_nxt = S_IDLE;
          end else begin
            st_nxt = S_QPOP;
            res_nxt.solve_status = ST_NOPATH;
            qwe = 1'b1; qwaddr = '0; qwdata = spos_nxt;
            qh_nxt = '0; qt_nxt = QW'(1);
            visit_nxt = 1'b1; cur_nxt = spos_nxt;
          end
        end else begin
          st_nxt = S_SCANR;
        end
      end
      S_QPOP: begin
        // Mark start visited on the first pass, then pop.
        if (visit_r) begin
          caddr = cur_r; st_nxt = S_NRD; nb_nxt = cur_r; visit_nxt = 1'b0;
          dir_nxt = 2'd0; cnt_nxt = '0;
          st_nxt = S_QDAT;
        end else if (qh_r < qt_r) begin
          qraddr = qh_r[AW-1:0]; qh_nxt = qh_r + 1'b1; st_nxt = S_QDAT;
        end else begin
          ovld_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      S_QDAT: begin
        if (cnt_r == '0 && nb_r == cur_r && dir_r == 2'd0 && qh_r == '0) begin
          // Start cell: set its visited bit keeping kind and parent.
          caddr = cur_r; cwe = 1'b1; cwdata = {crd_r[5:4], 1'b1, crd_r[2:0]};
          nb_nxt = '1; st_nxt = S_QPOP;
        end else begin
          cur_nxt = qrd_r;
          if (qrd_r == gpos_r) begin
            res_nxt.solve_status = ST_FOUND;
            steps_nxt = '0; guard_nxt = '0; cur_nxt = gpos_r;
            caddr = gpos_r; st_nxt = S_TRD;
          end else begin
            dir_nxt = DIR_UP; st_nxt = S_NRD;
          end
        end
      end
      S_NRD: begin
        nbase = cur_r; ndir = dir_r;
        nb_nxt = {nrow, ncol}; caddr = {nrow, ncol};
        if (nok) st_nxt = S_NCHK;
        else if (dir_r == DIR_RIGHT) st_nxt = S_QPOP;
        else dir_nxt = dir_r + 1'b1;
      end
      S_NCHK: begin
        caddr = nb_r;
        if (!crd_r[3] && crd_r[2:0] != K_WALL && qt_r < QW'(ROWS * COLS)) begin
          cwe = 1'b1;
          cwdata = {dir_r, 1'b1, (crd_r[2:0] == K_OPEN) ? K_VISITED : crd_r[2:0]};
          qwe = 1'b1; qwaddr = qt_r[AW-1:0]; qwdata = nb_r; qt_nxt = qt_r + 1'b1;
        end
        if (dir_r == DIR_RIGHT) st_nxt = S_QPOP;
        else begin dir_nxt = dir_r + 1'b1; st_nxt = S_NRD; end
      end
      S_TRD: begin
        caddr = cur_r;
        st_nxt = S_TCHK;
      end
      S_TCHK: begin
        nbase = cur_r; ndir = crd_r[5:4]; nback = 1'b1;
        caddr = {nrow, ncol};
        if (!nok || {nrow, ncol} == spos_r || guard_r >= QW'(ROWS * COLS)) begin
          res_nxt.path_steps = steps_r; ovld_nxt = 1'b1; st_nxt = S_IDLE;
        end else begin
          guard_nxt = guard_r + 1'b1;
          cur_nxt = {nrow, ncol};
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Overwrite kind with path, keep parent and visited bits.
        caddr = cur_r; cwe = 1'b1; cwdata = {crd_r[5:3], K_PATH};
        if (steps_r != 12'hFFF) steps_nxt = steps_r + 1'b1;
        st_nxt = S_TRD;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; ovld_r <= 1'b0; cnt_r <= '0; qh_r <= '0; qt_r <= '0;
      sseen_r <= 1'b0; gseen_r <= 1'b0; visit_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ovld_r <= ovld_nxt; cnt_r <= cnt_nxt; qh_r <= qh_nxt;
      qt_r <= qt_nxt; sseen_r <= sseen_nxt; gseen_r <= gseen_nxt; visit_r <= visit_nxt;
    end
    if (in_ch.valid && in_ch.ready) item_r <= in_ch.data;
    res_r <= res_nxt; cur_r <= cur_nxt; nb_r <= nb_nxt; dir_r <= dir_nxt;
    spos_r <= spos_nxt; gpos_r <= gpos_nxt; steps_r <= steps_nxt; guard_r <= guard_nxt;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (st_r == S_IDLE)) else $error("ready outside idle");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !ovld_r) else $error("result before work");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && !out_ch.ready) |=> (ovld_r && $stable(res_r))) else $error("result dropped");
  a_queue: assert property (@(posedge clk) disable iff (!rst_n)
    qh_r <= qt_r) else $error("queue head passed tail");
endmodule
`default_nettype wire

// File: dv/tb_grid_bfs_path_solver_unit.sv
// Self-checking testbench for the grid BFS path solver: stimulus, grid predictor and scoreboard.
`default_nettype none
module tb_grid_bfs_path_solver_unit;
  import gbps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NR = 64;
  localparam int NC = 64;
  localparam int NCELL = NR * NC;
  localparam int OP_UNUSED = 3;

  class maze_scoreboard;
    logic [2:0]  grid [NCELL];
    bit          seen [NCELL];
    logic [1:0]  came_from [NCELL];
    int          bfs_q [NCELL];
    out_item_t   pending [$];
    int          errors;

    function void clear_grid();
      foreach (grid[i]) grid[i] = K_OPEN;
      errors = 0;
    endfunction

    function void maze_solve(output out_item_t r);
      int start_at, goal_at, qh, qt, cur, rr, cc, n, p, steps, guard;
      bit have_s, have_g;
      int dr [4] = '{-1, 1, 0, 0};
      int dc [4] = '{0, 0, -1, 1};
      r = '0;
      have_s = 0; have_g = 0; start_at = 0; goal_at = 0;
      for (int i = 0; i < NCELL; i++) begin
        seen[i] = 0;
        if (grid[i] == K_START) begin start_at = i; have_s = 1; end
        if (grid[i] == K_GOAL) begin goal_at = i; have_g = 1; end
        if (grid[i] == K_PATH || grid[i] == K_VISITED) grid[i] = K_OPEN;
      end
      if (!have_s || !have_g) begin
        r.solve_status = ST_MISSING;
        return;
      end
      r.solve_status = ST_NOPATH;
      qh = 0; qt = 1; bfs_q[0] = start_at; seen[start_at] = 1;
      while (qh < qt) begin
        cur = bfs_q[qh];
        qh++;
        if (cur == goal_at) begin
          r.solve_status = ST_FOUND;
          // Walk back along the stored directions and mark intermediates.
          steps = 0; p = goal_at; guard = 0;
          forever begin
            rr = p / NC - dr[came_from[p]];
            cc = p % NC - dc[came_from[p]];
            if (rr < 0 || rr >= NR || cc < 0 || cc >= NC) break;
            p = rr * NC + cc;
            if (p == start_at || guard >= NCELL) break;
            guard++;
            grid[p] = K_PATH;
            steps++;
          end
          r.path_steps = (steps > 4095) ? 12'd4095 : 12'(steps);
          break;
        end
        for (int d = 0; d < 4; d++) begin
          rr = cur / NC + dr[d];
          cc = cur % NC + dc[d];
          if (rr < 0 || rr >= NR || cc < 0 || cc >= NC) continue;
          n = rr * NC + cc;
          if (seen[n] || grid[n] == K_WALL || qt >= NCELL) continue;
          seen[n] = 1;
          came_from[n] = 2'(d);
          bfs_q[qt] = n;
          qt++;
          if (grid[n] == K_OPEN) grid[n] = K_VISITED;
        end
      end
    endfunction

    function void note_beat(in_item_t it);
      out_item_t r;
      int idx;
      r = '0;
      idx = it.cell_row * NC + it.cell_col;
      case (it.opcode)
        OP_WRITE: grid[idx] = {1'b0, it.cell_kind};
        OP_SOLVE: maze_solve(r);
        OP_READ:  r.cell_state = grid[idx];
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_beat(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result beat %h", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.cell_state !== exp.cell_state) begin
        $error("cell_state: expected %0d, got %0d", exp.cell_state, got.cell_state);
        errors++;
      end
      if (got.solve_status !== exp.solve_status) begin
        $error("solve_status: expected %0d, got %0d", exp.solve_status, got.solve_status);
        errors++;
      end
      if (got.path_steps !== exp.path_steps) begin
        $error("path_steps: expected %0d, got %0d", exp.path_steps, got.path_steps);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  gbps_in_if  in_ch  (.clk(clk));
  gbps_out_if out_ch (.clk(clk));

  grid_bfs_path_solver_unit DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  maze_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int beats_sent = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Sink side: random stall, check each accepted result beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) board.check_beat(out_ch.data);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Valid stays high into the next beat; idle gaps and draining drop it.
  task automatic send_beat(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_beat(it);
    beats_sent++;
  endtask

  task automatic send_op(input int op, input int r, input int c, input int k);
    in_item_t it;
    it.opcode = 2'(op);
    it.cell_row = 6'(r);
    it.cell_col = 6'(c);
    it.cell_kind = 2'(k);
    send_beat(it);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed mazes: sparse walls, a start and a goal, then a solve and reads.
  task automatic random_maze(input int lo, input int hi);
    int r0, c0, n;
    r0 = $urandom_range(63 - hi);
    c0 = $urandom_range(63 - hi);
    n = $urandom_range(3, 12);
    for (int i = 0; i < n; i++)
      send_op(OP_WRITE, r0 + $urandom_range(hi), c0 + $urandom_range(hi), 2'(K_WALL));
    if ($urandom_range(9) != 0)
      send_op(OP_WRITE, r0 + $urandom_range(lo), c0 + $urandom_range(lo), 2'(K_START));
    if ($urandom_range(9) != 0)
      send_op(OP_WRITE, r0 + $urandom_range(hi), c0 + $urandom_range(hi), 2'(K_GOAL));
    if ($urandom_range(3) == 0)
      send_op($urandom_range(3), $urandom_range(63), $urandom_range(63), $urandom_range(3));
    send_op(OP_SOLVE, $urandom_range(63), $urandom_range(63), $urandom_range(3));
    for (int i = 0; i < 4; i++)
      send_op(OP_READ, r0 + $urandom_range(hi), c0 + $urandom_range(hi), $urandom_range(3));
    // Erase three random cells of the region so the next maze starts from a cleaner grid.
    for (int i = 0; i < 3; i++)
      send_op(OP_WRITE, r0 + $urandom_range(hi), c0 + $urandom_range(hi), 2'(K_OPEN));
  endtask

  initial begin
    board.clear_grid();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: missing endpoints, corners, extra endpoints, unused opcode.
    send_op(OP_SOLVE, 0, 0, 0);
    send_op(OP_WRITE, 0, 0, 2'(K_START));
    send_op(OP_SOLVE, 63, 63, 3);
    send_op(OP_WRITE, 63, 63, 2'(K_GOAL));
    send_op(OP_WRITE, 10, 10, 2'(K_GOAL));
    send_op(OP_WRITE, 5, 5, 2'(K_START));
    send_op(OP_SOLVE, 0, 0, 0);
    send_op(OP_READ, 0, 0, 0);
    send_op(OP_READ, 5, 6, 0);
    send_op(OP_READ, 63, 63, 0);
    send_op(OP_READ, 62, 63, 0);
    send_op(OP_WRITE, 63, 62, 2'(K_WALL));
    send_op(OP_WRITE, 62, 63, 2'(K_WALL));
    send_op(OP_SOLVE, 0, 0, 0);
    send_op(OP_UNUSED, 63, 63, 3);
    send_op(OP_READ, 63, 62, 0);
    send_op(OP_WRITE, 63, 63, 2'(K_OPEN));
    send_op(OP_WRITE, 10, 10, 2'(K_OPEN));
    send_op(OP_WRITE, 10, 11, 2'(K_GOAL));
    send_op(OP_SOLVE, 0, 0, 0);
    send_op(OP_READ, 5, 5, 0);
    send_op(OP_WRITE, 10, 11, 2'(K_OPEN));
    send_op(OP_WRITE, 5, 5, 2'(K_OPEN));
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 84 : 35) : 0;
      recv_stall_pct = (ph == 2) ? 84 : ((ph == 3) ? 35 : 0);
      while (beats_sent < 23 + 320 * (ph + 1)) begin
        if ($urandom_range(4) == 0)
          send_op($urandom_range(3), $urandom_range(63), $urandom_range(63), $urandom_range(3));
        else if ($urandom_range(9) == 0)
          random_maze(63, 63);
        else
          random_maze(3, 7);
      end
    end
    wait_drained();
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("grid_bfs_path_solver_unit test passed");
    end else begin
      $display("grid_bfs_path_solver_unit test failed");
    end
    $finish;
  end

  initial begin
    #900ms;
    $display("grid_bfs_path_solver_unit test failed");
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
hdl/gbps_pkg.sv
hdl/gbps_if.sv
hdl/gbps_nbr.sv
hdl/grid_bfs_path_solver_unit.sv
dv/tb_grid_bfs_path_solver_unit.sv
